FILE: design/drmc_pkg.sv
// ----------------------------------------------------------------------------
// drmc_pkg
// Shared types and constants for the decimal range multiple counter.
// ----------------------------------------------------------------------------
package drmc_pkg;

	localparam int MAX_DIGITS_DEF = 64;
	localparam int MAX_RESULTS    = 64;
	localparam int DIGIT_W        = 4;
	localparam int DIV_W          = 15;
	localparam int WIDE_W         = 19;
	localparam int DIGIT_MAX      = 9;
	localparam int DIGIT_BASE     = 10;

	typedef logic [DIGIT_W-1:0] digit_t;

	typedef struct packed {
		logic             done;
		digit_t           quot;
		logic [DIV_W-1:0] rem;
	} div_res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DRD,
		S_DLD,
		S_DWAIT,
		S_SRD,
		S_SCALC,
		S_ORD,
		S_OLD,
		S_OWAIT
	} state_t;

endpackage

FILE: design/drmc_digit_div.sv
// ----------------------------------------------------------------------------
// drmc_digit_div
// One decimal long division step: (rem * 10 + digit) / divisor, worked out
// by four compare-subtract iterations, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module drmc_digit_div
	import drmc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] rem_in,
	input  digit_t           digit_in,
	input  logic [DIV_W-1:0] dvsr,
	output div_res_t         res
);

	logic [WIDE_W-1:0] r_q;
	digit_t            quot_q;
	logic [1:0]        step_q;
	logic              busy_q;
	logic              done_q;
	logic [WIDE_W-1:0] r_load;
	logic [WIDE_W-1:0] trial;
	logic              ge;

	assign r_load = (WIDE_W'(rem_in) << 3) + (WIDE_W'(rem_in) << 1) + WIDE_W'(digit_in);
	assign trial  = WIDE_W'(dvsr) << step_q;
	assign ge     = (r_q >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd3;
			end else if (busy_q) begin
				if (step_q == 2'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q    <= r_load;
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge)
				r_q <= r_q - trial;
			quot_q[step_q] <= ge;
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.rem  = r_q[DIV_W-1:0];

endmodule

FILE: design/decimal_range_multiple_count.sv
// ----------------------------------------------------------------------------
// decimal_range_multiple_count
// After the upper bound's final digit, both bounds are divided by the divisor
// in a shared long division unit (upper bound first), their quotients are
// subtracted, and the count is sent out one result word per digit.
// Input: a word is taken only while idle; no input is taken while busy.
// Reset: lengths, flags and control clear; divisor returns to 1.
// ----------------------------------------------------------------------------
module decimal_range_multiple_count
	import drmc_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             divisor_we,
	input  logic [DIV_W-1:0] divisor_wdata,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic             which_number,
	input  digit_t           digit,
	input  logic             last_digit,
	output logic             result_valid,
	input  logic             result_stall,
	output digit_t           result_digit,
	output logic             last,
	output logic             length_error
);

	localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int LW = $clog2(MAX_DIGITS + 1);

	state_t state_q, state_d;

	digit_t lo_mem [MAX_DIGITS];
	digit_t up_mem [MAX_DIGITS];
	digit_t lq_mem [MAX_DIGITS];
	digit_t uq_mem [MAX_DIGITS];
	digit_t df_mem [MAX_DIGITS];

	logic [LW-1:0]    lo_len_q, up_len_q;
	logic             lo_closed_q, ovf_q;
	logic [DIV_W-1:0] divisor_q;
	logic [AW-1:0]    p_q, idx_q, top_q;
	logic             phase_q, a_nz_q, zero_q, err_q;
	logic [DIV_W-1:0] rem_q;
	logic [1:0]       cy_q;
	digit_t           lo_rd_q, up_rd_q, lq_rd_q, uq_rd_q, df_rd_q;
	logic             res_valid_q, res_last_q, res_err_q;
	digit_t           res_digit_q;

	logic             accept;
	digit_t           d_in;
	logic [LW-1:0]    wa_lo;
	logic [LW-1:0]    src_len;
	logic [AW-1:0]    dig_addr;
	logic             dig_ok;
	digit_t           cur_digit;
	logic [DIV_W-1:0] dvsr;
	div_res_t         div_res;
	logic [5:0]       sum;
	digit_t           dd;
	logic [1:0]       cy_n;
	logic [AW-1:0]    top_n;
	logic             p_first, p_final;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && (state_q == S_IDLE);
	assign d_in       = (digit > digit_t'(DIGIT_MAX)) ? digit_t'(DIGIT_MAX) : digit;
	assign wa_lo      = lo_closed_q ? '0 : lo_len_q;
	assign dvsr       = (divisor_q == '0) ? DIV_W'(1) : divisor_q;
	assign p_first    = (p_q == '0);
	assign p_final    = (p_q == AW'(MAX_DIGITS - 1));

	assign src_len   = phase_q ? lo_len_q : up_len_q;
	assign dig_ok    = LW'(p_q) < src_len;
	assign dig_addr  = AW'(src_len - LW'(1) - LW'(p_q));
	assign cur_digit = dig_ok ? (phase_q ? lo_rd_q : up_rd_q) : '0;

	assign sum = 6'(uq_rd_q) - 6'(lq_rd_q) + {{4{cy_q[1]}}, cy_q};
	always_comb begin
		if (sum[5]) begin
			dd   = DIGIT_W'(sum + 6'(DIGIT_BASE));
			cy_n = 2'b11;
		end else if (sum >= 6'(DIGIT_BASE)) begin
			dd   = DIGIT_W'(sum - 6'(DIGIT_BASE));
			cy_n = 2'b01;
		end else begin
			dd   = DIGIT_W'(sum);
			cy_n = 2'b00;
		end
	end
	assign top_n = (dd != '0) ? p_q : top_q;

	drmc_digit_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DLD),
		.rem_in   (rem_q),
		.digit_in (cur_digit),
		.dvsr     (dvsr),
		.res      (div_res)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && which_number && last_digit)
					state_d = S_DRD;
			end
			S_DRD:   state_d = S_DLD;
			S_DLD:   state_d = S_DWAIT;
			S_DWAIT: begin
				if (div_res.done)
					state_d = (p_first && phase_q) ? S_SRD : S_DRD;
			end
			S_SRD:   state_d = S_SCALC;
			S_SCALC: state_d = p_final ? S_ORD : S_SRD;
			S_ORD:   state_d = S_OLD;
			S_OLD:   state_d = S_OWAIT;
			S_OWAIT: begin
				if (!result_stall)
					state_d = (idx_q == '0) ? S_IDLE : S_ORD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lo_len_q    <= '0;
			up_len_q    <= '0;
			lo_closed_q <= 1'b0;
			ovf_q       <= 1'b0;
			divisor_q   <= DIV_W'(1);
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (divisor_we)
				divisor_q <= divisor_wdata;
			if (accept) begin
				if (!which_number) begin
					lo_closed_q <= last_digit;
					if (wa_lo < LW'(MAX_DIGITS)) begin
						lo_len_q <= wa_lo + LW'(1);
					end else begin
						lo_len_q <= wa_lo;
						ovf_q    <= 1'b1;
					end
				end else begin
					if (up_len_q < LW'(MAX_DIGITS))
						up_len_q <= up_len_q + LW'(1);
					else
						ovf_q <= 1'b1;
				end
			end
			if (state_q == S_OLD)
				res_valid_q <= 1'b1;
			if (state_q == S_OWAIT && !result_stall) begin
				res_valid_q <= 1'b0;
				if (idx_q == '0) begin
					lo_len_q    <= '0;
					up_len_q    <= '0;
					lo_closed_q <= 1'b0;
					ovf_q       <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				p_q     <= AW'(MAX_DIGITS - 1);
				phase_q <= 1'b0;
				rem_q   <= '0;
				a_nz_q  <= 1'b0;
			end
			S_DLD: begin
				if (phase_q && cur_digit != '0)
					a_nz_q <= 1'b1;
			end
			S_DWAIT: begin
				if (div_res.done) begin
					rem_q <= div_res.rem;
					if (!p_first) begin
						p_q <= p_q - AW'(1);
					end else if (!phase_q) begin
						phase_q <= 1'b1;
						rem_q   <= '0;
						p_q     <= AW'(MAX_DIGITS - 1);
					end else begin
						cy_q  <= {1'b0, (div_res.rem == '0) && a_nz_q};
						p_q   <= '0;
						top_q <= '0;
					end
				end
			end
			S_SCALC: begin
				cy_q  <= cy_n;
				top_q <= top_n;
				if (!p_final) begin
					p_q <= p_q + AW'(1);
				end else begin
					zero_q <= (cy_n == 2'b11);
					if (cy_n == 2'b11) begin
						idx_q <= '0;
						err_q <= ovf_q;
					end else if (int'(top_n) >= MAX_RESULTS) begin
						idx_q <= AW'(MAX_RESULTS - 1);
						err_q <= 1'b1;
					end else begin
						idx_q <= top_n;
						err_q <= ovf_q;
					end
				end
			end
			S_OLD: begin
				res_digit_q <= zero_q ? '0 : df_rd_q;
				res_last_q  <= (idx_q == '0);
				res_err_q   <= err_q;
			end
			S_OWAIT: begin
				if (!result_stall && idx_q != '0)
					idx_q <= idx_q - AW'(1);
			end
			default: begin
			end
		endcase
	end

	// digit and working stores
	always_ff @(posedge clk) begin
		if (accept && !which_number && wa_lo < LW'(MAX_DIGITS))
			lo_mem[AW'(wa_lo)] <= d_in;
		if (accept && which_number && up_len_q < LW'(MAX_DIGITS))
			up_mem[AW'(up_len_q)] <= d_in;
		if (state_q == S_DWAIT && div_res.done) begin
			if (phase_q)
				lq_mem[p_q] <= div_res.quot;
			else
				uq_mem[p_q] <= div_res.quot;
		end
		if (state_q == S_SCALC)
			df_mem[p_q] <= dd;
		lo_rd_q <= lo_mem[dig_addr];
		up_rd_q <= up_mem[dig_addr];
		lq_rd_q <= lq_mem[p_q];
		uq_rd_q <= uq_mem[p_q];
		df_rd_q <= df_mem[idx_q];
	end

	assign result_valid = res_valid_q;
	assign result_digit = res_digit_q;
	assign last         = res_last_q;
	assign length_error = res_err_q;

endmodule

FILE: bench/decimal_range_multiple_count_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_range_multiple_count_tb
// Loads lower and upper bounds digit by digit and checks every digit of the
// count of divisor multiples in the range against a predictor kept in step
// with each accepted word. The run covers several divisors, sender and
// receiver idling, and one long receiver hold-off while words keep coming.
// ----------------------------------------------------------------------------
module decimal_range_multiple_count_tb;
	import drmc_pkg::*;

	localparam int NDIG       = MAX_DIGITS_DEF;
	localparam int SETTLE     = 32;
	localparam int TAIL       = 1500;
	localparam int HOLD_LEN   = 4000;
	localparam int NPHASE     = 6;
	localparam int PER_PHASE  = 12;

	typedef struct {
		logic   which;
		digit_t value;
		logic   closing;
	} word_t;

	typedef struct {
		digit_t value;
		logic   final_digit;
		logic   overflow;
	} count_digit_t;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             divisor_we    = 1'b0;
	logic [DIV_W-1:0] divisor_wdata = '0;
	logic             item_valid    = 1'b0;
	logic             item_stall;
	logic             which_number  = 1'b0;
	digit_t           digit         = '0;
	logic             last_digit    = 1'b0;
	logic             result_valid;
	logic             result_stall  = 1'b0;
	digit_t           result_digit;
	logic             last;
	logic             length_error;

	word_t        pending_words [$];
	count_digit_t count_digits [$];
	word_t        next_word;
	count_digit_t want;
	int           words_queued  = 0;
	int           fail_count    = 0;
	int           send_idle_pct = 0;
	int           stall_pct     = 0;
	int           taken_total   = 0;
	int           taken_seen    = 0;
	bit           hold_req      = 1'b0;
	bit           hold_seen     = 1'b0;
	int           hold_left     = 0;

	// predictor state
	int               lower_num [NDIG];
	int               upper_num [NDIG];
	int               lower_len     = 0;
	int               upper_len     = 0;
	bit               overflow_seen = 1'b0;
	bit               lower_closed  = 1'b0;
	logic [DIV_W-1:0] divisor_now   = DIV_W'(1);

	decimal_range_multiple_count dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.divisor_we   (divisor_we),
		.divisor_wdata(divisor_wdata),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.which_number (which_number),
		.digit        (digit),
		.last_digit   (last_digit),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_digit (result_digit),
		.last         (last),
		.length_error (length_error)
	);

	always #5 clk = ~clk;

	function automatic void count_multiples();
		int           a [NDIG];
		int           b [NDIG];
		int           qa [NDIG];
		int           qb [NDIG];
		int           diff [NDIG];
		int           k, rem, borrow, sub, n, p;
		bit           err;
		count_digit_t e;
		k = (divisor_now == 0) ? 1 : int'(divisor_now);
		for (p = 0; p < NDIG; p++) begin
			a[p] = (p < lower_len) ? lower_num[lower_len - 1 - p] : 0;
			b[p] = (p < upper_len) ? upper_num[upper_len - 1 - p] : 0;
		end
		// lower bound minus one, held at zero
		p = 0;
		while (p < NDIG && a[p] == 0)
			p++;
		if (p < NDIG) begin
			a[p]--;
			while (p > 0) begin
				p--;
				a[p] = DIGIT_MAX;
			end
		end
		rem = 0;
		for (p = NDIG - 1; p >= 0; p--) begin
			rem = rem * DIGIT_BASE + b[p];
			qb[p] = rem / k;
			rem = rem % k;
		end
		rem = 0;
		for (p = NDIG - 1; p >= 0; p--) begin
			rem = rem * DIGIT_BASE + a[p];
			qa[p] = rem / k;
			rem = rem % k;
		end
		borrow = 0;
		for (p = 0; p < NDIG; p++) begin
			sub = qa[p] + borrow;
			if (qb[p] >= sub) begin
				diff[p] = qb[p] - sub;
				borrow = 0;
			end else begin
				diff[p] = qb[p] + DIGIT_BASE - sub;
				borrow = 1;
			end
		end
		if (borrow != 0)
			for (p = 0; p < NDIG; p++)
				diff[p] = 0;
		n = NDIG;
		while (n > 1 && diff[n - 1] == 0)
			n--;
		err = overflow_seen;
		if (n > MAX_RESULTS) begin
			n = MAX_RESULTS;
			err = 1'b1;
		end
		for (p = n - 1; p >= 0; p--) begin
			e.value = digit_t'(diff[p]);
			e.final_digit = (p == 0);
			e.overflow = err;
			count_digits.push_back(e);
		end
		lower_len = 0;
		upper_len = 0;
		overflow_seen = 1'b0;
		lower_closed = 1'b0;
	endfunction

	function automatic void record_word(logic upper, digit_t value, logic closing);
		int d;
		d = (value > DIGIT_MAX) ? DIGIT_MAX : int'(value);
		if (!upper) begin
			if (lower_closed) begin
				lower_len = 0;
				lower_closed = 1'b0;
			end
			if (lower_len < NDIG)
				lower_num[lower_len++] = d;
			else
				overflow_seen = 1'b1;
			if (closing)
				lower_closed = 1'b1;
		end else begin
			if (upper_len < NDIG)
				upper_num[upper_len++] = d;
			else
				overflow_seen = 1'b1;
			if (closing)
				count_multiples();
		end
	endfunction

	// drive the next word, or hold the current one until it is taken
	always @(negedge clk) begin
		if (!item_valid || taken_seen != taken_total) begin
			taken_seen = taken_total;
			if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_word = pending_words.pop_front();
				item_valid <= 1'b1;
				which_number <= next_word.which;
				digit <= next_word.value;
				last_digit <= next_word.closing;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				record_word(which_number, digit, last_digit);
				taken_total++;
			end
			if (result_valid && !result_stall) begin
				if (count_digits.size() == 0) begin
					$error("unexpected result word: result_digit %0d last %0b length_error %0b",
						result_digit, last, length_error);
					fail_count++;
				end else begin
					want = count_digits.pop_front();
					if (result_digit !== want.value) begin
						$error("result_digit: expected %0d, got %0d", want.value, result_digit);
						fail_count++;
					end
					if (last !== want.final_digit) begin
						$error("last: expected %0b, got %0b", want.final_digit, last);
						fail_count++;
					end
					if (length_error !== want.overflow) begin
						$error("length_error: expected %0b, got %0b", want.overflow, length_error);
						fail_count++;
					end
				end
			end
		end
	end

	task automatic queue_word(logic upper, digit_t value, logic closing);
		word_t w;
		w.which = upper;
		w.value = value;
		w.closing = closing;
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic queue_number(logic upper, int len);
		int     i;
		digit_t d;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0)
				d = digit_t'($urandom_range(15, 10));
			else
				d = digit_t'($urandom_range(DIGIT_MAX));
			queue_word(upper, d, i == len - 1);
		end
	endtask

	task automatic queue_range(int lower_digits, int upper_digits);
		if (lower_digits > 0)
			queue_number(1'b0, lower_digits);
		queue_number(1'b1, upper_digits);
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return $urandom_range(68, 62);
		if (r < 15)
			return $urandom_range(20, 7);
		return $urandom_range(6, 1);
	endfunction

	task automatic queue_random_words(int budget);
		int target, r, la, lb;
		target = words_queued + budget;
		while (words_queued < target) begin
			r = $urandom_range(99);
			if (r < 12) begin
				queue_word(1'($urandom_range(1)), digit_t'($urandom_range(15)),
					1'($urandom_range(1)));
			end else begin
				la = pick_len();
				lb = pick_len();
				// keep the upper bound mostly at least as long as the lower
				if (lb < la && $urandom_range(3) != 0)
					lb = la;
				queue_range((r < 17) ? 0 : la, lb);
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || item_valid || count_digits.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_divisor(logic [DIV_W-1:0] value);
		@(negedge clk);
		divisor_we <= 1'b1;
		divisor_wdata <= value;
		@(negedge clk);
		divisor_we <= 1'b0;
		divisor_now = value;
		@(posedge clk);
	endtask

	initial begin
		int ph;
		int phase_divisor [NPHASE];
		int phase_send [NPHASE];
		int phase_stall [NPHASE];
		phase_divisor = '{32767, 0, 7, 0, 1, 13};
		phase_send    = '{0, 86, 0, 25, 0, 0};
		phase_stall   = '{0, 0, 86, 25, 0, 0};
		phase_divisor[3] = $urandom_range(500, 2);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lower bound zero
		queue_word(1'b0, 4'd0, 1'b1);
		queue_word(1'b1, 4'd9, 1'b1);
		// no lower bound, oversized digit
		queue_word(1'b1, 4'd15, 1'b1);
		// upper below lower
		queue_word(1'b0, 4'd9, 1'b1);
		queue_word(1'b1, 4'd1, 1'b1);
		// a second lower bound replaces the first
		queue_word(1'b0, 4'd5, 1'b1);
		queue_word(1'b0, 4'd3, 1'b1);
		queue_word(1'b1, 4'd7, 1'b1);
		queue_word(1'b0, 4'd1, 1'b0);
		queue_word(1'b0, 4'd0, 1'b1);
		queue_word(1'b1, 4'd9, 1'b0);
		queue_word(1'b1, 4'd9, 1'b0);
		queue_word(1'b1, 4'd10, 1'b1);
		// zero count, leading zeros on the lower bound
		queue_word(1'b0, 4'd0, 1'b0);
		queue_word(1'b0, 4'd0, 1'b0);
		queue_word(1'b0, 4'd1, 1'b1);
		queue_word(1'b1, 4'd0, 1'b1);
		// bounds interleaved
		queue_word(1'b1, 4'd4, 1'b0);
		queue_word(1'b0, 4'd8, 1'b1);
		queue_word(1'b1, 4'd2, 1'b1);
		queue_word(1'b0, 4'd12, 1'b1);
		queue_word(1'b1, 4'd14, 1'b0);
		queue_word(1'b1, 4'd13, 1'b1);

		for (ph = 0; ph < NPHASE; ph++) begin
			wait_drained();
			write_divisor(DIV_W'(phase_divisor[ph]));
			send_idle_pct = phase_send[ph];
			stall_pct = phase_stall[ph];
			if (ph == 4)
				hold_req = ~hold_req;
			if (ph == 0)
				queue_range(2, 65);
			queue_random_words(PER_PHASE);
		end

		wait_drained();
		repeat (TAIL) @(posedge clk);
		if (fail_count == 0)
			$display("decimal_range_multiple_count_tb OK");
		else
			$display("decimal_range_multiple_count_tb NOT OK");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("decimal_range_multiple_count_tb NOT OK");
		$finish;
	end

endmodule
